// ----- src/rsc_pkg.sv -----
// Package for the radix string converter.
// Holds the request and result types, register indexes, character codes and
// the sequencer state type. Depends on nothing.
package rsc_pkg;

  // Field and register widths.
  localparam int CHAR_W     = 8;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int BASE_W     = 5;
  localparam int DIGIT_W    = 4;
  localparam int ALPHA_SIZE = 16;
  localparam int ALPHA_W    = ALPHA_SIZE * CHAR_W;

  // Largest base either alphabet may use; larger settings are clamped to it.
  localparam int MAX_BASE = 16;

  // Default width of the value being converted.
  localparam int DEF_VALUE_BITS = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_LO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_HI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_BASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_LO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_HI     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_BASE   = 3'd5;

  // Reset values of the configuration registers: alphabet "01", base 2.
  localparam logic [CFG_W-1:0]  ALPHA_LO_RESET = 64'h3130;
  localparam logic [CFG_W-1:0]  ALPHA_HI_RESET = 64'h0;
  localparam logic [BASE_W-1:0] BASE_RESET     = 5'd2;

  // Sign characters.
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

  // One input request.
  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              end_of_number;
  } in_item_t;

  // One result character.
  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last_char;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } state_t;

endpackage

// ----- src/rsc_lookup.sv -----
// Source alphabet lookup for the radix string converter.
// Compares one character against all alphabet entries in parallel.
// Depends on rsc_pkg.
module rsc_lookup
  import rsc_pkg::*;
(
  input  logic [CHAR_W-1:0]  ch,
  input  logic [ALPHA_W-1:0] alpha,
  input  logic [BASE_W-1:0]  base,
  output logic [BASE_W-1:0]  digit
);

  // Scan from the top so that the lowest matching position wins.
  // A character with no match in the first base entries reads as base.
  always_comb begin
    digit = base;
    for (int k = ALPHA_SIZE - 1; k >= 0; k--) begin
      if ((BASE_W'(k) < base) && (alpha[k*CHAR_W +: CHAR_W] == ch)) begin
        digit = BASE_W'(k);
      end
    end
  end

endmodule

// ----- src/rsc_div.sv -----
// Restoring divider for the radix string converter.
// Divides an unsigned value by a small base, one quotient bit per cycle.
// Depends on rsc_pkg.
module rsc_div
  import rsc_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [BASE_W-1:0]     divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [DIGIT_W-1:0]    remainder
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [BASE_W-1:0]     div_r, div_nxt;

  logic [BASE_W-1:0] shifted;
  logic [BASE_W-1:0] diff;
  logic              fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  // The partial remainder stays below the divisor, so it fits in a digit.
  assign shifted = {rem_r, q_r[VALUE_BITS-1]};
  assign fits    = (shifted >= div_r);
  assign diff    = shifted - div_r;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      q_nxt   = dividend;
      rem_nxt = '0;
      div_nxt = divisor;
    end else if (run_r) begin
      q_nxt   = {q_r[VALUE_BITS-2:0], fits};
      rem_nxt = fits ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(VALUE_BITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

// ----- src/rsc_digit_mem.sv -----
// Digit store for the radix string converter.
// Single write port, single registered read port; contents undefined at reset.
// Depends on rsc_pkg.
module rsc_digit_mem
  import rsc_pkg::*;
#(
  parameter int DEPTH  = DEF_VALUE_BITS,
  parameter int ADDR_W = $clog2(DEF_VALUE_BITS)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [DIGIT_W-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [DIGIT_W-1:0] rdata
);

  logic [DIGIT_W-1:0] mem_r [DEPTH];
  logic [DIGIT_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/radix_string_converter_core.sv -----
// Top level of the radix string converter.
// Accumulates source characters, then converts the value with a single divider
// and streams the target characters. Depends on rsc_pkg, rsc_lookup, rsc_div
// and rsc_digit_mem.
//
//   Channel   Ports                       Transfer
//   --------  --------------------------  ------------------------------------
//   request   start, busy, in_data        start high and busy low at the edge
//   result    out_valid, out_data         out_valid high, no stall
//   config    cfg_we, cfg_index, cfg_wdata  cfg_we high at the edge
//
// A request that is not the end of a number leaves busy low.
// The final request keeps busy high while the divider produces the digits,
// one quotient bit per cycle, then while a minus sign for a negative value
// and each digit read back through the digit store are emitted.
// Reset is synchronous and active low; it restores the default alphabets.
// The receiver cannot stall: each result is on out_data for one cycle only.
module radix_string_converter_core
  import rsc_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int ADDR_W = $clog2(VALUE_BITS);
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int PROD_W = VALUE_BITS + BASE_W;

  // Configuration registers.
  logic [CFG_W-1:0]  from_lo_r, from_hi_r, to_lo_r, to_hi_r;
  logic [BASE_W-1:0] from_base_r, to_base_r;

  // Sequencer and number state.
  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  neg_flag_r, neg_flag_nxt;
  logic                  at_start_r, at_start_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  sign_r, sign_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  logic [BASE_W-1:0]     from_base_c, to_base_c;
  logic [BASE_W-1:0]     src_digit;
  logic [PROD_W-1:0]     prod;
  logic [VALUE_BITS-1:0] acc_step;
  logic [VALUE_BITS-1:0] signed_val;
  logic                  val_neg;
  logic [VALUE_BITS-1:0] val_abs;
  logic [CNT_W-1:0]      cnt_dec;
  logic [ALPHA_W-1:0]    to_alpha;
  logic                  is_sign;

  logic                  div_go;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;
  logic                  mem_we;
  logic                  mem_re;
  logic [DIGIT_W-1:0]    mem_rdata;

  // Clamp a base setting into the supported range.
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    if (b < BASE_W'(2)) begin
      r = BASE_W'(2);
    end else if (b > BASE_W'(MAX_BASE)) begin
      r = BASE_W'(MAX_BASE);
    end else begin
      r = b;
    end
    return r;
  endfunction

  assign from_base_c = clamp_base(from_base_r);
  assign to_base_c   = clamp_base(to_base_r);
  assign to_alpha    = {to_hi_r, to_lo_r};

  // Source character to digit value.
  rsc_lookup u_lookup (
    .ch    (in_data.in_char),
    .alpha ({from_hi_r, from_lo_r}),
    .base  (from_base_c),
    .digit (src_digit)
  );

  // Accumulate step: acc * base + digit, wrapping at the value width.
  assign prod     = PROD_W'(acc_r) * PROD_W'(from_base_c);
  assign acc_step = prod[VALUE_BITS-1:0] + VALUE_BITS'(src_digit);

  // Apply the sign and take the magnitude of the two's complement value.
  assign signed_val = neg_flag_r ? (~acc_r + VALUE_BITS'(1)) : acc_r;
  assign val_neg    = signed_val[VALUE_BITS-1];
  assign val_abs    = val_neg ? (~signed_val + VALUE_BITS'(1)) : signed_val;

  assign cnt_dec = cnt_r - CNT_W'(1);
  assign is_sign = at_start_r &&
                   ((in_data.in_char == CH_PLUS) || (in_data.in_char == CH_MINUS));

  // Single divider for the target base.
  rsc_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (mag_r),
    .divisor   (to_base_c),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Digits are stored least significant first and read back in reverse.
  rsc_digit_mem #(
    .DEPTH  (VALUE_BITS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (div_rem),
    .re    (mem_re),
    .raddr (cnt_dec[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  // Sequencer: next state, datapath updates and result strobe.
  always_comb begin
    state_nxt    = state_r;
    acc_nxt      = acc_r;
    neg_flag_nxt = neg_flag_r;
    at_start_nxt = at_start_r;
    mag_nxt      = mag_r;
    sign_nxt     = sign_r;
    cnt_nxt      = cnt_r;
    div_go       = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    out_valid    = 1'b0;
    out_data     = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (is_sign) begin
            neg_flag_nxt = (in_data.in_char == CH_MINUS);
          end else begin
            acc_nxt = acc_step;
          end
          at_start_nxt = 1'b0;
          if (in_data.end_of_number) begin
            at_start_nxt = 1'b1;
            state_nxt    = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        mag_nxt      = val_abs;
        sign_nxt     = val_neg;
        acc_nxt      = '0;
        neg_flag_nxt = 1'b0;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_go    = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          mag_nxt = div_quot;
          if (div_quot == '0) begin
            state_nxt = sign_r ? ST_SIGN : ST_READ;
          end else begin
            state_nxt = ST_DIV_GO;
          end
        end
      end
      ST_SIGN: begin
        out_valid          = 1'b1;
        out_data.out_char  = CH_MINUS;
        out_data.last_char = 1'b0;
        state_nxt          = ST_READ;
      end
      ST_READ: begin
        mem_re    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid          = 1'b1;
        out_data.out_char  = to_alpha[{mem_rdata, 3'b000} +: CHAR_W];
        out_data.last_char = (cnt_r == CNT_W'(1));
        cnt_nxt            = cnt_dec;
        state_nxt          = (cnt_r == CNT_W'(1)) ? ST_IDLE : ST_READ;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      acc_r      <= '0;
      neg_flag_r <= 1'b0;
      at_start_r <= 1'b1;
      cnt_r      <= '0;
      sign_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      acc_r      <= acc_nxt;
      neg_flag_r <= neg_flag_nxt;
      at_start_r <= at_start_nxt;
      cnt_r      <= cnt_nxt;
      sign_r     <= sign_nxt;
    end
  end

  // Magnitude being converted.
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_lo_r   <= ALPHA_LO_RESET;
      from_hi_r   <= ALPHA_HI_RESET;
      from_base_r <= BASE_RESET;
      to_lo_r     <= ALPHA_LO_RESET;
      to_hi_r     <= ALPHA_HI_RESET;
      to_base_r   <= BASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FROM_LO:   from_lo_r   <= cfg_wdata;
        CFG_FROM_HI:   from_hi_r   <= cfg_wdata;
        CFG_FROM_BASE: from_base_r <= cfg_wdata[BASE_W-1:0];
        CFG_TO_LO:     to_lo_r     <= cfg_wdata;
        CFG_TO_HI:     to_hi_r     <= cfg_wdata;
        CFG_TO_BASE:   to_base_r   <= cfg_wdata[BASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
